// ===== src/uvs_pkg.sv =====
// ----------------------------------------------------------------------------
// UV sphere vertex generator package
// Shared widths, pipeline depths, fixed-point constants and arithmetic helpers.
// ----------------------------------------------------------------------------
package uvs_pkg;

    // Field widths.
    localparam int RAD_W = 16;
    localparam int SEC_W = 11;
    localparam int STK_W = 10;
    localparam int POS_W = 17;
    localparam int NRM_W = 16;
    localparam int TEX_W = 17;
    localparam int PH_W  = 32;
    localparam int SC_W  = 32;
    localparam int XW    = 30;

    // Pipeline depths.
    localparam int DIV_STAGES = 8;
    localparam int SC_LAT     = 9;
    localparam int SCL_LAT    = 4;
    localparam int TEX_DLY    = SC_LAT + SCL_LAT;
    localparam int PIPE_LAT   = 1 + DIV_STAGES + SC_LAT + SCL_LAT;

    // Fraction bits of the divider lanes.
    localparam int SEC_FRAC = 32;
    localparam int STK_FRAC = 31;
    localparam int TEX_FRAC = 16;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RADIUS  = 2'd0;
    localparam logic [1:0] CFG_SECTORS = 2'd1;
    localparam logic [1:0] CFG_STACKS  = 2'd2;

    localparam logic [RAD_W-1:0] RADIUS_RST  = 16'd256;
    localparam logic [SEC_W-1:0] SECTORS_RST = 11'd36;
    localparam logic [STK_W-1:0] STACKS_RST  = 10'd18;

    // Pi in Q30 and the quarter-turn phase.
    localparam logic [31:0]     PI_Q30      = 32'd3373259426;
    localparam logic [PH_W-1:0] QUARTER_PH  = 32'h4000_0000;

    // Reciprocals floor(2^30 / d) for the Taylor term divisions.
    localparam logic [XW-1:0] RCP_6     = 30'((64'd1 << 30) / 64'd6);
    localparam logic [XW-1:0] RCP_24    = 30'((64'd1 << 30) / 64'd24);
    localparam logic [XW-1:0] RCP_120   = 30'((64'd1 << 30) / 64'd120);
    localparam logic [XW-1:0] RCP_720   = 30'((64'd1 << 30) / 64'd720);
    localparam logic [XW-1:0] RCP_5040  = 30'((64'd1 << 30) / 64'd5040);
    localparam logic [XW-1:0] RCP_40320 = 30'((64'd1 << 30) / 64'd40320);

    localparam int POS_LIM = 65535;
    localparam int NRM_LIM = 16384;

    typedef logic signed [SC_W-1:0] t_sc;

    // Q30 product of two unsigned Q30 values, truncated.
    function automatic logic [XW-1:0] mul_q30(input logic [XW-1:0] a,
                                              input logic [XW-1:0] b);
        logic [2*XW-1:0] p;
        p = (2*XW)'(a) * (2*XW)'(b);
        return p[2*XW-1:XW];
    endfunction

    // Corrects a reciprocal quotient estimate that may be one low.
    function automatic logic [XW-1:0] div_fix(input logic [XW-1:0] x,
                                              input logic [XW-1:0] q0,
                                              input logic [15:0]   d);
        logic [XW+15:0] rem;
        rem = (XW+16)'(x) - (XW+16)'(q0) * (XW+16)'(d);
        return (rem >= (XW+16)'(d)) ? q0 + 30'd1 : q0;
    endfunction

    // Shift right by n with rounding to nearest, half away from zero.
    function automatic logic signed [66:0] rnd_shr(input logic signed [66:0] v,
                                                   input int unsigned n);
        logic signed [66:0] half;
        logic signed [66:0] neg;
        logic signed [66:0] sum;
        half = 67'sd1 <<< (n - 1);
        neg  = v[66] ? 67'sd1 : 67'sd0;
        sum  = v + half - neg;
        return sum >>> n;
    endfunction

    // Symmetric saturation to +-lim.
    function automatic logic signed [17:0] clamp_sym(input logic signed [66:0] v,
                                                     input int lim);
        logic signed [66:0] l;
        l = 67'(lim);
        if (v > l) begin
            return 18'(l);
        end
        if (v < -l) begin
            return 18'(-l);
        end
        return 18'(v);
    endfunction

endpackage

// ===== src/uvs_div.sv =====
// ----------------------------------------------------------------------------
// UV sphere divider lane
// Pipelined restoring divider: floor((num * 2^FRAC_W + den/2) / den) for num <= den.
// ----------------------------------------------------------------------------
module uvs_div #(
    parameter int DEN_W  = 11,
    parameter int FRAC_W = 32,
    parameter int STAGES = 8
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DEN_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic [FRAC_W:0]   o_quo
);

    localparam int STEPS = (FRAC_W + STAGES - 1) / STAGES;

    logic [FRAC_W-1:0] w_bias;
    logic              w_init_int;
    logic [DEN_W-1:0]  w_init_rem;

    logic [DEN_W-1:0]  w_rem_in [STAGES];
    logic [FRAC_W:0]   w_quo_in [STAGES];
    logic [DEN_W-1:0]  n_rem    [STAGES];
    logic [FRAC_W:0]   n_quo    [STAGES];
    logic [DEN_W-1:0]  r_rem    [STAGES];
    logic [FRAC_W:0]   r_quo    [STAGES];

    // The rounding bias den/2 sits in the low bits of the shifted numerator.
    assign w_bias     = {{(FRAC_W-DEN_W+1){1'b0}}, i_den[DEN_W-1:1]};
    assign w_init_int = (i_num >= i_den);
    assign w_init_rem = w_init_int ? (i_num - i_den) : i_num;

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        if (s == 0) begin : g_first
            assign w_rem_in[s] = w_init_rem;
            assign w_quo_in[s] = {w_init_int, {FRAC_W{1'b0}}};
        end else begin : g_next
            assign w_rem_in[s] = r_rem[s-1];
            assign w_quo_in[s] = r_quo[s-1];
        end

        always_comb begin : p_step
            logic [DEN_W:0]  rem;
            logic [FRAC_W:0] quo;
            rem = {1'b0, w_rem_in[s]};
            quo = w_quo_in[s];
            for (int g = 0; g < STEPS; g++) begin
                if (s * STEPS + g < FRAC_W) begin
                    rem = {rem[DEN_W-1:0], w_bias[FRAC_W-1-(s*STEPS+g)]};
                    if (rem >= {1'b0, i_den}) begin
                        rem = rem - {1'b0, i_den};
                        quo[FRAC_W-1-(s*STEPS+g)] = 1'b1;
                    end
                end
            end
            n_rem[s] = rem[DEN_W-1:0];
            n_quo[s] = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo[STAGES-1];

endmodule

// ===== src/uvs_sincos.sv =====
// ----------------------------------------------------------------------------
// UV sphere sine and cosine unit
// Octant folding and an eighth-order Taylor series in Q30, nine register stages.
// ----------------------------------------------------------------------------
module uvs_sincos (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [uvs_pkg::PH_W-1:0] i_phase,
    output uvs_pkg::t_sc             o_sin,
    output uvs_pkg::t_sc             o_cos
);

    localparam int XW = uvs_pkg::XW;

    logic [2:0]      w_oct;
    logic [XW-1:0]   w_ff;
    logic [61:0]     n_a_prod;
    logic [62:0]     w_xsum;

    logic [61:0]     r_a_prod;
    logic [2:0]      r_a_oct;
    logic [XW-1:0]   r_b_x;
    logic [2:0]      r_b_oct;
    logic [XW-1:0]   r_c_x, r_c_x2;
    logic [2:0]      r_c_oct;
    logic [XW-1:0]   r_d_x, r_d_x2, r_d_x3, r_d_x4;
    logic [2:0]      r_d_oct;
    logic [XW-1:0]   r_e_x, r_e_x2, r_e_x3, r_e_x4, r_e_x5, r_e_x6;
    logic [2:0]      r_e_oct;
    logic [XW-1:0]   r_f_x, r_f_x2, r_f_x3, r_f_x4, r_f_x5, r_f_x6, r_f_x7, r_f_x8;
    logic [2:0]      r_f_oct;
    logic [XW-1:0]   r_g_x, r_g_x2, r_g_x3, r_g_x4, r_g_x5, r_g_x6, r_g_x7, r_g_x8;
    logic [XW-1:0]   r_g_q3, r_g_q4, r_g_q5, r_g_q6, r_g_q7, r_g_q8;
    logic [2:0]      r_g_oct;
    logic [XW-1:0]   r_h_x, r_h_x2;
    logic [XW-1:0]   r_h_d3, r_h_d4, r_h_d5, r_h_d6, r_h_d7, r_h_d8;
    logic [2:0]      r_h_oct;
    logic [XW:0]     w_s, w_c;
    uvs_pkg::t_sc    w_sp, w_cp;
    uvs_pkg::t_sc    n_sin, n_cos;
    uvs_pkg::t_sc    r_sin, r_cos;

    // Odd octants run the angle backward from the octant's end.
    assign w_oct    = i_phase[31:29];
    assign w_ff     = w_oct[0] ? (30'h2000_0000 - {1'b0, i_phase[28:0]})
                               : {1'b0, i_phase[28:0]};
    assign n_a_prod = w_ff * 62'(uvs_pkg::PI_Q30);
    assign w_xsum   = {1'b0, r_a_prod} + (63'd1 << 30);

    assign w_s = ((XW+1)'(r_h_x) + (XW+1)'(r_h_d5)) - ((XW+1)'(r_h_d3) + (XW+1)'(r_h_d7));
    assign w_c = ((31'd1 << 30) + (XW+1)'(r_h_d4) + (XW+1)'(r_h_d8))
               - ((XW+1)'(r_h_x2 >> 1) + (XW+1)'(r_h_d6));
    assign w_sp = uvs_pkg::t_sc'({1'b0, w_s});
    assign w_cp = uvs_pkg::t_sc'({1'b0, w_c});

    always_comb begin
        case (r_h_oct)
            3'd0:    begin n_sin = w_sp;  n_cos = w_cp;  end
            3'd1:    begin n_sin = w_cp;  n_cos = w_sp;  end
            3'd2:    begin n_sin = w_cp;  n_cos = -w_sp; end
            3'd3:    begin n_sin = w_sp;  n_cos = -w_cp; end
            3'd4:    begin n_sin = -w_sp; n_cos = -w_cp; end
            3'd5:    begin n_sin = -w_cp; n_cos = -w_sp; end
            3'd6:    begin n_sin = -w_cp; n_cos = w_sp;  end
            default: begin n_sin = -w_sp; n_cos = w_cp;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_prod <= n_a_prod;
            r_a_oct  <= w_oct;

            r_b_x    <= w_xsum[60:31];
            r_b_oct  <= r_a_oct;

            r_c_x    <= r_b_x;
            r_c_x2   <= uvs_pkg::mul_q30(r_b_x, r_b_x);
            r_c_oct  <= r_b_oct;

            r_d_x    <= r_c_x;
            r_d_x2   <= r_c_x2;
            r_d_x3   <= uvs_pkg::mul_q30(r_c_x, r_c_x2);
            r_d_x4   <= uvs_pkg::mul_q30(r_c_x2, r_c_x2);
            r_d_oct  <= r_c_oct;

            r_e_x    <= r_d_x;
            r_e_x2   <= r_d_x2;
            r_e_x3   <= r_d_x3;
            r_e_x4   <= r_d_x4;
            r_e_x5   <= uvs_pkg::mul_q30(r_d_x3, r_d_x2);
            r_e_x6   <= uvs_pkg::mul_q30(r_d_x4, r_d_x2);
            r_e_oct  <= r_d_oct;

            r_f_x    <= r_e_x;
            r_f_x2   <= r_e_x2;
            r_f_x3   <= r_e_x3;
            r_f_x4   <= r_e_x4;
            r_f_x5   <= r_e_x5;
            r_f_x6   <= r_e_x6;
            r_f_x7   <= uvs_pkg::mul_q30(r_e_x5, r_e_x2);
            r_f_x8   <= uvs_pkg::mul_q30(r_e_x6, r_e_x2);
            r_f_oct  <= r_e_oct;

            // Quotient estimates by reciprocal; each is exact or one low.
            r_g_x    <= r_f_x;
            r_g_x2   <= r_f_x2;
            r_g_x3   <= r_f_x3;
            r_g_x4   <= r_f_x4;
            r_g_x5   <= r_f_x5;
            r_g_x6   <= r_f_x6;
            r_g_x7   <= r_f_x7;
            r_g_x8   <= r_f_x8;
            r_g_q3   <= uvs_pkg::mul_q30(r_f_x3, uvs_pkg::RCP_6);
            r_g_q4   <= uvs_pkg::mul_q30(r_f_x4, uvs_pkg::RCP_24);
            r_g_q5   <= uvs_pkg::mul_q30(r_f_x5, uvs_pkg::RCP_120);
            r_g_q6   <= uvs_pkg::mul_q30(r_f_x6, uvs_pkg::RCP_720);
            r_g_q7   <= uvs_pkg::mul_q30(r_f_x7, uvs_pkg::RCP_5040);
            r_g_q8   <= uvs_pkg::mul_q30(r_f_x8, uvs_pkg::RCP_40320);
            r_g_oct  <= r_f_oct;

            r_h_x    <= r_g_x;
            r_h_x2   <= r_g_x2;
            r_h_d3   <= uvs_pkg::div_fix(r_g_x3, r_g_q3, 16'd6);
            r_h_d4   <= uvs_pkg::div_fix(r_g_x4, r_g_q4, 16'd24);
            r_h_d5   <= uvs_pkg::div_fix(r_g_x5, r_g_q5, 16'd120);
            r_h_d6   <= uvs_pkg::div_fix(r_g_x6, r_g_q6, 16'd720);
            r_h_d7   <= uvs_pkg::div_fix(r_g_x7, r_g_q7, 16'd5040);
            r_h_d8   <= uvs_pkg::div_fix(r_g_x8, r_g_q8, 16'd40320);
            r_h_oct  <= r_g_oct;

            r_sin    <= n_sin;
            r_cos    <= n_cos;
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

// ===== src/uvs_scale.sv =====
// ----------------------------------------------------------------------------
// UV sphere output scaling
// Radius and angle products, rounding and saturation, four register stages.
// ----------------------------------------------------------------------------
module uvs_scale (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [uvs_pkg::RAD_W-1:0]        i_radius,
    input  uvs_pkg::t_sc                     i_sin_u,
    input  uvs_pkg::t_sc                     i_cos_u,
    input  uvs_pkg::t_sc                     i_sin_v,
    input  uvs_pkg::t_sc                     i_cos_v,
    output logic signed [uvs_pkg::POS_W-1:0] o_pos_x,
    output logic signed [uvs_pkg::POS_W-1:0] o_pos_y,
    output logic signed [uvs_pkg::POS_W-1:0] o_pos_z,
    output logic signed [uvs_pkg::NRM_W-1:0] o_normal_x,
    output logic signed [uvs_pkg::NRM_W-1:0] o_normal_y,
    output logic signed [uvs_pkg::NRM_W-1:0] o_normal_z
);

    logic signed [16:0]               w_rad;
    logic signed [48:0]               r1_rc, r1_rs;
    logic signed [63:0]               r1_nx, r1_ny;
    uvs_pkg::t_sc                     r1_sin_u, r1_cos_v, r1_sin_v;
    logic signed [34:0]               r2_xy;
    uvs_pkg::t_sc                     r2_cos_v, r2_sin_v;
    logic signed [uvs_pkg::POS_W-1:0] r2_pz, r3_pz, r4_pz, r4_px, r4_py;
    logic signed [uvs_pkg::NRM_W-1:0] r2_nx, r2_ny, r2_nz, r3_nx, r3_ny, r3_nz;
    logic signed [uvs_pkg::NRM_W-1:0] r4_nx, r4_ny, r4_nz;
    logic signed [66:0]               r3_px, r3_py;

    assign w_rad = $signed({1'b0, i_radius});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_rc    <= 49'(w_rad) * 49'(i_cos_u);
            r1_rs    <= 49'(w_rad) * 49'(i_sin_u);
            r1_nx    <= 64'(i_cos_u) * 64'(i_cos_v);
            r1_ny    <= 64'(i_cos_u) * 64'(i_sin_v);
            r1_sin_u <= i_sin_u;
            r1_cos_v <= i_cos_v;
            r1_sin_v <= i_sin_v;

            // The radial term keeps Q16 for the second product.
            r2_xy    <= 35'(uvs_pkg::rnd_shr(67'(r1_rc), 14));
            r2_pz    <= 17'(uvs_pkg::clamp_sym(uvs_pkg::rnd_shr(67'(r1_rs), 30),
                                               uvs_pkg::POS_LIM));
            r2_nx    <= 16'(uvs_pkg::clamp_sym(uvs_pkg::rnd_shr(67'(r1_nx), 46),
                                               uvs_pkg::NRM_LIM));
            r2_ny    <= 16'(uvs_pkg::clamp_sym(uvs_pkg::rnd_shr(67'(r1_ny), 46),
                                               uvs_pkg::NRM_LIM));
            r2_nz    <= 16'(uvs_pkg::clamp_sym(uvs_pkg::rnd_shr(67'(r1_sin_u), 16),
                                               uvs_pkg::NRM_LIM));
            r2_cos_v <= r1_cos_v;
            r2_sin_v <= r1_sin_v;

            r3_px    <= 67'(r2_xy) * 67'(r2_cos_v);
            r3_py    <= 67'(r2_xy) * 67'(r2_sin_v);
            r3_pz    <= r2_pz;
            r3_nx    <= r2_nx;
            r3_ny    <= r2_ny;
            r3_nz    <= r2_nz;

            r4_px    <= 17'(uvs_pkg::clamp_sym(uvs_pkg::rnd_shr(r3_px, 46),
                                               uvs_pkg::POS_LIM));
            r4_py    <= 17'(uvs_pkg::clamp_sym(uvs_pkg::rnd_shr(r3_py, 46),
                                               uvs_pkg::POS_LIM));
            r4_pz    <= r3_pz;
            r4_nx    <= r3_nx;
            r4_ny    <= r3_ny;
            r4_nz    <= r3_nz;
        end
    end

    assign o_pos_x    = r4_px;
    assign o_pos_y    = r4_py;
    assign o_pos_z    = r4_pz;
    assign o_normal_x = r4_nx;
    assign o_normal_y = r4_ny;
    assign o_normal_z = r4_nz;

endmodule

// ===== src/uv_sphere_vertex_generator_core.sv =====
// Throughput: one vertex per cycle; every stage is a register that advances together.
// The pipeline holds whenever the final output register is full and not taken.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
// UV sphere vertex generator
// Turns a (stack, sector) grid point into a vertex position, unit normal and
// texture coordinates, one vertex per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_core #(
    parameter int MAX_SECTORS = 1024,
    parameter int MAX_STACKS  = 512
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input item channel.
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [uvs_pkg::STK_W-1:0]        i_stack_index,
    input  logic [uvs_pkg::SEC_W-1:0]        i_sector_index,
    // Result channel.
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [uvs_pkg::POS_W-1:0] o_pos_x,
    output logic signed [uvs_pkg::POS_W-1:0] o_pos_y,
    output logic signed [uvs_pkg::POS_W-1:0] o_pos_z,
    output logic signed [uvs_pkg::NRM_W-1:0] o_normal_x,
    output logic signed [uvs_pkg::NRM_W-1:0] o_normal_y,
    output logic signed [uvs_pkg::NRM_W-1:0] o_normal_z,
    output logic [uvs_pkg::TEX_W-1:0]        o_tex_s,
    output logic [uvs_pkg::TEX_W-1:0]        o_tex_t,
    // Configuration write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [1:0]                       i_cfg_index,
    input  logic [uvs_pkg::RAD_W-1:0]        i_cfg_data
);

    localparam int PIPE_LAT = uvs_pkg::PIPE_LAT;
    localparam int TEX_DLY  = uvs_pkg::TEX_DLY;

    // Configuration registers.
    logic [uvs_pkg::RAD_W-1:0] r_sphere_radius;
    logic [uvs_pkg::SEC_W-1:0] r_sector_count;
    logic [uvs_pkg::STK_W-1:0] r_stack_count;

    logic [uvs_pkg::SEC_W-1:0] w_nsec;
    logic [uvs_pkg::STK_W-1:0] w_nstk;

    // Pipeline control: one valid bit per stage, all stages move together.
    logic                      w_adv;
    logic [PIPE_LAT-1:0]       r_vld;
    logic [PIPE_LAT-1:0]       n_vld;

    logic [uvs_pkg::STK_W-1:0] r_s0_i, n_s0_i;
    logic [uvs_pkg::SEC_W-1:0] r_s0_j, n_s0_j;

    logic [uvs_pkg::SEC_FRAC:0] w_q_sec;
    logic [uvs_pkg::STK_FRAC:0] w_q_stk;
    logic [uvs_pkg::TEX_W-1:0]  w_tex_s, w_tex_t;
    logic [uvs_pkg::PH_W-1:0]   w_ph_sec, w_ph_stk;

    logic [uvs_pkg::TEX_W-1:0]  r_tex_s_dly [TEX_DLY];
    logic [uvs_pkg::TEX_W-1:0]  r_tex_t_dly [TEX_DLY];

    uvs_pkg::t_sc w_sin_u, w_cos_u, w_sin_v, w_cos_v;

    // The configuration port never stalls; the user must write only while the block is
    // idle (the block does not enforce it), so in-flight items can read the registers directly.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sphere_radius <= uvs_pkg::RADIUS_RST;
            r_sector_count  <= uvs_pkg::SECTORS_RST;
            r_stack_count   <= uvs_pkg::STACKS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                uvs_pkg::CFG_RADIUS:  r_sphere_radius <= i_cfg_data;
                uvs_pkg::CFG_SECTORS: r_sector_count  <= i_cfg_data[uvs_pkg::SEC_W-1:0];
                uvs_pkg::CFG_STACKS:  r_stack_count   <= i_cfg_data[uvs_pkg::STK_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective counts: a zero count acts as one, and counts saturate at the
    // configured maximum.
    always_comb begin
        if (r_sector_count == '0) begin
            w_nsec = 11'd1;
        end else if ({6'b0, r_sector_count} > 17'(MAX_SECTORS)) begin
            w_nsec = 11'(MAX_SECTORS);
        end else begin
            w_nsec = r_sector_count;
        end
        if (r_stack_count == '0) begin
            w_nstk = 10'd1;
        end else if ({7'b0, r_stack_count} > 17'(MAX_STACKS)) begin
            w_nstk = 10'(MAX_STACKS);
        end else begin
            w_nstk = r_stack_count;
        end
    end

    // A new transaction enters whenever the output register is empty or is
    // being drained in this cycle; a stall freezes every stage at once.
    assign w_adv      = !r_vld[PIPE_LAT-1] || i_out_ready;
    assign o_in_ready = w_adv;

    assign n_vld = {r_vld[PIPE_LAT-2:0], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= n_vld;
        end
    end

    // Stage 0 saturates the indices to the effective counts.
    assign n_s0_i = (i_stack_index > w_nstk) ? w_nstk : i_stack_index;
    assign n_s0_j = (i_sector_index > w_nsec) ? w_nsec : i_sector_index;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0_i <= n_s0_i;
            r_s0_j <= n_s0_j;
        end
    end

    // Four divider lanes in parallel, each eight stages deep. The angle lanes
    // produce turn phases; the texture lanes produce the 16-bit fractions.
    uvs_div #(
        .DEN_W  (uvs_pkg::SEC_W),
        .FRAC_W (uvs_pkg::SEC_FRAC),
        .STAGES (uvs_pkg::DIV_STAGES)
    ) u_div_sec (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_s0_j),
        .i_den (w_nsec),
        .o_quo (w_q_sec)
    );

    uvs_div #(
        .DEN_W  (uvs_pkg::STK_W),
        .FRAC_W (uvs_pkg::STK_FRAC),
        .STAGES (uvs_pkg::DIV_STAGES)
    ) u_div_stk (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_s0_i),
        .i_den (w_nstk),
        .o_quo (w_q_stk)
    );

    uvs_div #(
        .DEN_W  (uvs_pkg::SEC_W),
        .FRAC_W (uvs_pkg::TEX_FRAC),
        .STAGES (uvs_pkg::DIV_STAGES)
    ) u_div_tex_s (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_s0_j),
        .i_den (w_nsec),
        .o_quo (w_tex_s)
    );

    uvs_div #(
        .DEN_W  (uvs_pkg::STK_W),
        .FRAC_W (uvs_pkg::TEX_FRAC),
        .STAGES (uvs_pkg::DIV_STAGES)
    ) u_div_tex_t (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_s0_i),
        .i_den (w_nstk),
        .o_quo (w_tex_t)
    );

    // A full turn of sector phase wraps to zero. The stack angle starts at the
    // north pole, a quarter turn, and runs down by half a turn over the stacks.
    assign w_ph_sec = w_q_sec[uvs_pkg::PH_W-1:0];
    assign w_ph_stk = uvs_pkg::QUARTER_PH - w_q_stk;

    uvs_sincos u_sincos_u (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_phase (w_ph_stk),
        .o_sin   (w_sin_u),
        .o_cos   (w_cos_u)
    );

    uvs_sincos u_sincos_v (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_phase (w_ph_sec),
        .o_sin   (w_sin_v),
        .o_cos   (w_cos_v)
    );

    uvs_scale u_scale (
        .i_clk      (i_clk),
        .i_en       (w_adv),
        .i_radius   (r_sphere_radius),
        .i_sin_u    (w_sin_u),
        .i_cos_u    (w_cos_u),
        .i_sin_v    (w_sin_v),
        .i_cos_v    (w_cos_v),
        .o_pos_x    (o_pos_x),
        .o_pos_y    (o_pos_y),
        .o_pos_z    (o_pos_z),
        .o_normal_x (o_normal_x),
        .o_normal_y (o_normal_y),
        .o_normal_z (o_normal_z)
    );

    // Texture coordinates are ready early and wait in a delay line until the
    // geometry of the same vertex reaches the output register.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tex_s_dly[0] <= w_tex_s;
            r_tex_t_dly[0] <= w_tex_t;
            for (int k = 1; k < TEX_DLY; k++) begin
                r_tex_s_dly[k] <= r_tex_s_dly[k-1];
                r_tex_t_dly[k] <= r_tex_t_dly[k-1];
            end
        end
    end

    assign o_tex_s     = r_tex_s_dly[TEX_DLY-1];
    assign o_tex_t     = r_tex_t_dly[TEX_DLY-1];
    assign o_out_valid = r_vld[PIPE_LAT-1];

    // Texture coordinates never exceed one, since indices saturate to counts.
    a_tex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_tex_s <= 17'd65536) && (o_tex_t <= 17'd65536))
        else $error("texture coordinate above one");

    // Normals stay inside the saturated unit range.
    a_normal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_normal_x <= 16'sd16384) && (o_normal_x >= -16'sd16384)
                     && (o_normal_y <= 16'sd16384) && (o_normal_y >= -16'sd16384)
                     && (o_normal_z <= 16'sd16384) && (o_normal_z >= -16'sd16384))
        else $error("normal outside unit range");

    // Reset leaves the pipeline empty.
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule
